@@ rtl/vpa_pkg.sv @@
// Shared types and codes for the variable partition allocator.
package vpa_pkg;

    // Request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_FIT   = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOT_FND  = 3'd3;
    localparam logic [2:0] ST_BAD_SIZE = 3'd4;

    // Policy codes
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    // Configuration register indexes
    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_REGION = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [15:0] req_units;
        logic [15:0] owner_id;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] granted_id;
        logic [15:0] block_start;
        logic [15:0] block_length;
    } t_rsp;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // capture request, reset scan
        logic owned_step; // examine one owned slot
        logic hole_step;  // examine one hole slot
        logic commit;     // update tables, produce result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic owned_last;
        logic hole_last;
    } t_sts;

endpackage

@@ rtl/vpa_ctrl.sv @@
// Controller state machine: sequences the owned scan, hole scan and commit.
module vpa_ctrl
    import vpa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_OWNED = 4'b0010,
        S_HOLE  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_start) n_state = S_OWNED;
            S_OWNED: if (i_sts.owned_last) n_state = S_HOLE;
            S_HOLE:  if (i_sts.hole_last) n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    assign o_busy           = (r_state != S_IDLE);
    assign o_cmd.load       = (r_state == S_IDLE) && i_start;
    assign o_cmd.owned_step = (r_state == S_OWNED);
    assign o_cmd.hole_step  = (r_state == S_HOLE);
    assign o_cmd.commit     = (r_state == S_DONE);

endmodule

@@ rtl/vpa_dp.sv @@
// Datapath: hole and owned tables, scan registers and table update.
module vpa_dp
    import vpa_pkg::*;
#(
    parameter int OWNED_SLOTS = 16,
    parameter int ADDR_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_req        i_req,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output t_sts        o_sts,
    output logic        o_done,
    output t_rsp        o_rsp
);

    localparam int HOLE_SLOTS = OWNED_SLOTS + 1;
    localparam int OW = (OWNED_SLOTS > 1) ? $clog2(OWNED_SLOTS) : 1;
    localparam int HW = $clog2(HOLE_SLOTS);

    // Tables
    logic [ADDR_BITS-1:0] r_hs [HOLE_SLOTS];
    logic [ADDR_BITS-1:0] r_hl [HOLE_SLOTS];
    logic [HOLE_SLOTS-1:0] r_hv;
    logic [15:0]          r_oid [OWNED_SLOTS];
    logic [ADDR_BITS-1:0] r_os  [OWNED_SLOTS];
    logic [ADDR_BITS-1:0] r_ol  [OWNED_SLOTS];
    logic [OWNED_SLOTS-1:0] r_ov;

    logic [1:0]  r_policy;
    logic [15:0] r_id_ctr;

    // Request and scan state
    t_req        r_req;
    logic [OW-1:0] r_oi;
    logic [HW-1:0] r_hi;
    logic          r_slot_found;
    logic [OW-1:0] r_slot;
    logic          r_pick_found;
    logic [HW-1:0] r_pick;
    logic          r_below_found, r_above_found, r_free_found;
    logic [HW-1:0] r_below, r_above, r_free;
    logic [ADDR_BITS-1:0] r_fs, r_fl;
    logic          r_done;
    t_rsp          r_rsp, n_rsp;

    // Current elements under scan
    logic [ADDR_BITS-1:0] w_hs, w_hl, w_ps, w_pl;
    logic [ADDR_BITS:0]   w_hend, w_fend;
    logic                 w_better, w_fits;
    logic [ADDR_BITS-1:0] w_size;

    assign w_hs   = r_hs[r_hi];
    assign w_hl   = r_hl[r_hi];
    assign w_ps   = r_hs[r_pick];
    assign w_pl   = r_hl[r_pick];
    assign w_hend = {1'b0, w_hs} + {1'b0, w_hl};
    assign w_fend = {1'b0, r_fs} + {1'b0, r_fl};
    assign w_size = ADDR_BITS'(r_req.req_units);
    assign w_fits = r_hv[r_hi] && ({16'd0, w_hl} >= {{ADDR_BITS{1'b0}}, r_req.req_units});

    // Policy comparison against current pick
    always_comb begin
        case (r_policy)
            POL_BEST:  w_better = (w_hl < w_pl) || (w_hl == w_pl && w_hs < w_ps);
            POL_WORST: w_better = (w_hl > w_pl) || (w_hl == w_pl && w_hs < w_ps);
            default:   w_better = (w_hs < w_ps);
        endcase
    end

    assign o_sts.owned_last = (32'(r_oi) == OWNED_SLOTS - 1);
    assign o_sts.hole_last  = (32'(r_hi) == HOLE_SLOTS - 1);

    // Result of the request under commit
    always_comb begin
        n_rsp = '0;
        if (r_req.req_type == REQ_ALLOC) begin
            if (r_req.req_units == 16'd0) begin
                n_rsp.status = ST_BAD_SIZE;
            end else if (!r_slot_found) begin
                n_rsp.status = ST_FULL;
            end else if (!r_pick_found) begin
                n_rsp.status = ST_NO_FIT;
            end else begin
                n_rsp.status       = ST_OK;
                n_rsp.granted_id   = r_id_ctr;
                n_rsp.block_start  = 16'(w_ps);
                n_rsp.block_length = r_req.req_units;
            end
        end else begin
            n_rsp.granted_id = r_req.owner_id;
            if (!r_slot_found) begin
                n_rsp.status = ST_NOT_FND;
            end else begin
                n_rsp.status       = ST_OK;
                n_rsp.block_start  = 16'(r_fs);
                n_rsp.block_length = 16'(r_fl);
            end
        end
    end

    // Result strobe in the cycle after commit, unless a config write coincides
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else          r_done <= i_cmd.commit && !i_cfg_we;
    end

    // Reset, config writes (priority over commands), load, scan and commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_FIRST;
            r_id_ctr <= '0;
            r_hv     <= HOLE_SLOTS'(ADDR_BITS'(17'd1024) != '0);
            r_hs[0]  <= '0;
            r_hl[0]  <= ADDR_BITS'(17'd1024);
            r_ov     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_POLICY: r_policy <= i_cfg_data[1:0];
                REG_REGION: begin
                    r_hs[0] <= '0;
                    r_hl[0] <= ADDR_BITS'(i_cfg_data);
                    r_hv    <= HOLE_SLOTS'(ADDR_BITS'(i_cfg_data) != '0);
                    r_ov    <= '0;
                end
                default: ;
            endcase
        end else if (i_cmd.load) begin
            r_req         <= i_req;
            r_oi          <= '0;
            r_hi          <= '0;
            r_slot_found  <= 1'b0;
            r_pick_found  <= 1'b0;
            r_below_found <= 1'b0;
            r_above_found <= 1'b0;
            r_free_found  <= 1'b0;
            r_pick        <= '0;
            if (i_req.req_type == REQ_ALLOC) r_id_ctr <= r_id_ctr + 16'd1;
        end else if (i_cmd.owned_step) begin
            if (!r_slot_found) begin
                if (r_req.req_type == REQ_ALLOC ? !r_ov[r_oi]
                    : (r_ov[r_oi] && r_oid[r_oi] == r_req.owner_id)) begin
                    r_slot_found <= 1'b1;
                    r_slot       <= r_oi;
                    r_fs         <= r_os[r_oi];
                    r_fl         <= r_ol[r_oi];
                end
            end
            if (!o_sts.owned_last) r_oi <= r_oi + 1'b1;
        end else if (i_cmd.hole_step) begin
            if (r_req.req_type == REQ_ALLOC) begin
                if (w_fits && (!r_pick_found || w_better)) begin
                    r_pick_found <= 1'b1;
                    r_pick       <= r_hi;
                end
            end else begin
                if (r_hv[r_hi]) begin
                    if (w_hend == {1'b0, r_fs}) begin
                        r_below_found <= 1'b1;
                        r_below       <= r_hi;
                    end else if ({1'b0, w_hs} == w_fend) begin
                        r_above_found <= 1'b1;
                        r_above       <= r_hi;
                    end
                end else if (!r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free       <= r_hi;
                end
            end
            if (!o_sts.hole_last) r_hi <= r_hi + 1'b1;
        end else if (i_cmd.commit) begin
            r_rsp <= n_rsp;
            if (r_req.req_type == REQ_ALLOC) begin
                if (r_req.req_units != 16'd0 && r_slot_found && r_pick_found) begin
                    r_ov[r_slot]  <= 1'b1;
                    r_oid[r_slot] <= r_id_ctr;
                    r_os[r_slot]  <= w_ps;
                    r_ol[r_slot]  <= w_size;
                    r_hs[r_pick]  <= w_ps + w_size;
                    r_hl[r_pick]  <= w_pl - w_size;
                    if (w_pl == w_size) r_hv[r_pick] <= 1'b0;
                end
            end else if (r_slot_found) begin
                r_ov[r_slot] <= 1'b0;
                if (r_below_found) begin
                    r_hl[r_below] <= r_hl[r_below] + r_fl
                                   + (r_above_found ? r_hl[r_above] : '0);
                    if (r_above_found) r_hv[r_above] <= 1'b0;
                end else if (r_above_found) begin
                    r_hs[r_above] <= r_fs;
                    r_hl[r_above] <= r_hl[r_above] + r_fl;
                end else if (r_free_found) begin
                    r_hv[r_free] <= 1'b1;
                    r_hs[r_free] <= r_fs;
                    r_hl[r_free] <= r_fl;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

@@ rtl/variable_partition_allocator_top.sv @@
// Top level of the variable partition allocator.
//
//  channel   handshake            payload
//  request   i_start / o_busy     i_req  (t_req)
//  result    o_done (strobe)      o_rsp  (t_rsp)
//  config    i_cfg_we             i_cfg_index, i_cfg_data
//
// Each request runs a serial scan of every owned slot, then a serial scan of every
// hole slot (OWNED_SLOTS + 1 of them), then a commit, and the result follows.
// Busy is high from the owned scan through the commit.
// The result strobe o_done is high for one cycle, the first cycle with busy low,
// unless a config write meets the commit; a new request can be taken in that same cycle.
// Synchronous reset: one hole [0,1024), no owned blocks, first fit.
// The receiver cannot stall; o_done is not held, but o_rsp keeps its value until the next commit.
module variable_partition_allocator_top
    import vpa_pkg::*;
#(
    parameter int OWNED_SLOTS = 16,
    parameter int ADDR_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  t_req        i_req,
    output logic        o_done,
    output t_rsp        o_rsp,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    vpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy)
    );

    vpa_dp #(
        .OWNED_SLOTS (OWNED_SLOTS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_sts       (w_sts),
        .o_done      (o_done),
        .o_rsp       (o_rsp)
    );

endmodule
